// File: src/mrpt_pkg.sv
// Package for the 64-bit Miller-Rabin prime test: constants, controller states,
// command/status structs between controller and datapath, witness tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrpt_pkg;

  localparam int VALUE_WIDTH   = 64;
  localparam int MAX_WITNESSES = 12;
  localparam int WIDX_W        = 4;
  localparam int TWOS_W        = 7;
  localparam int MCNT_W        = $clog2(VALUE_WIDTH);

  localparam logic [VALUE_WIDTH-1:0] LIMIT_A = VALUE_WIDTH'(2047);
  localparam logic [VALUE_WIDTH-1:0] LIMIT_B = VALUE_WIDTH'(1373653);
  localparam logic [VALUE_WIDTH-1:0] LIMIT_C = VALUE_WIDTH'(25326001);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLASS, ST_PREP, ST_SMALL, ST_RINIT, ST_EXPCHK, ST_MULA, ST_SQB_GO,
    ST_MULB, ST_XCHK, ST_LOOPCHK, ST_MULX, ST_SQCHK, ST_NEXTW, ST_RESULT
  } mrpt_state_t;

  typedef enum logic [1:0] {MUL_ACC, MUL_SQB, MUL_SQX} mrpt_mulop_t;

  typedef enum logic [1:0] {SET_A, SET_B, SET_C, SET_WIDE} mrpt_set_t;

  typedef struct packed {
    logic        load;
    logic        prep_start;
    logic        prep_step;
    logic        round_init;
    logic        mul_start;
    mrpt_mulop_t mul_op;
    logic        mul_step;
    logic        left_load;
    logic        left_dec;
    logic        widx_clr;
    logic        widx_inc;
  } mrpt_cmd_t;

  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic prep_last;
    logic small_div;
    logic exp_zero;
    logic exp_bit0;
    logic mul_last;
    logic x_one_or_nm1;
    logic x_nm1;
    logic left_gt1;
    logic last_witness;
  } mrpt_status_t;

  function automatic logic [5:0] witness(input mrpt_set_t s, input logic [WIDX_W-1:0] i);
    logic [5:0] w;
    w = 6'd2;
    unique case (s)
      SET_A: w = 6'd2;
      SET_B: w = (i == WIDX_W'(0)) ? 6'd2 : 6'd3;
      SET_C: begin
        unique case (i)
          WIDX_W'(0): w = 6'd2;
          WIDX_W'(1): w = 6'd3;
          default:    w = 6'd5;
        endcase
      end
      SET_WIDE: begin
        unique case (i)
          WIDX_W'(0):  w = 6'd2;
          WIDX_W'(1):  w = 6'd3;
          WIDX_W'(2):  w = 6'd5;
          WIDX_W'(3):  w = 6'd7;
          WIDX_W'(4):  w = 6'd11;
          WIDX_W'(5):  w = 6'd13;
          WIDX_W'(6):  w = 6'd17;
          WIDX_W'(7):  w = 6'd19;
          WIDX_W'(8):  w = 6'd23;
          WIDX_W'(9):  w = 6'd29;
          WIDX_W'(10): w = 6'd31;
          default:     w = 6'd37;
        endcase
      end
      default: w = 6'd2;
    endcase
    return w;
  endfunction

  function automatic logic [WIDX_W-1:0] set_count(input mrpt_set_t s);
    logic [WIDX_W-1:0] c;
    c = WIDX_W'(1);
    unique case (s)
      SET_A:    c = WIDX_W'(1);
      SET_B:    c = WIDX_W'(2);
      SET_C:    c = WIDX_W'(3);
      SET_WIDE: c = WIDX_W'(MAX_WITNESSES);
      default:  c = WIDX_W'(1);
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/mrpt_dp.sv
// Datapath of the Miller-Rabin prime test: candidate, odd part, residues,
// power/base/exponent registers and a bit-serial modular multiplier.
// Depends on mrpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrpt_dp import mrpt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic                   treat_signed,
  input  wire mrpt_cmd_t              cmd,
  output mrpt_status_t                sts
);
  localparam int W = VALUE_WIDTH;

  logic [W-1:0]        n_r, d_r, sr_r, acc_r, base_r, exp_r, mb_r, macc_r;
  logic                neg_r;
  logic [TWOS_W-1:0]   twos_r, left_r;
  logic [1:0]          r3_r;
  logic [2:0]          r5_r, r7_r;
  logic [MCNT_W-1:0]   cnt_r, mcnt_r;
  logic [WIDX_W-1:0]   widx_r;
  mrpt_mulop_t         op_r;
  mrpt_set_t           set_c;

  logic [W-1:0] nm1, mul_a, mul_b, t1, s1, prod;
  logic [W:0]   t, s;
  logic [2:0]   v3;
  logic [3:0]   v5, v7;

  assign nm1 = n_r - W'(1);

  always_comb begin
    priority if (n_r < LIMIT_A) set_c = SET_A;
    else if (n_r < LIMIT_B)     set_c = SET_B;
    else if (n_r < LIMIT_C)     set_c = SET_C;
    else                        set_c = SET_WIDE;
  end

  // multiplier operand selection
  always_comb begin
    unique case (op_r)
      MUL_ACC: mul_a = acc_r;
      MUL_SQB: mul_a = base_r;
      default: mul_a = acc_r;
    endcase
    unique case (cmd.mul_op)
      MUL_ACC: mul_b = base_r;
      MUL_SQB: mul_b = base_r;
      default: mul_b = acc_r;
    endcase
  end

  // one multiplier bit: double, reduce, add, reduce
  always_comb begin
    t    = {macc_r, 1'b0};
    t1   = (t >= {1'b0, n_r}) ? W'(t - {1'b0, n_r}) : t[W-1:0];
    s    = {1'b0, t1} + (mb_r[W-1] ? {1'b0, mul_a} : '0);
    s1   = (s >= {1'b0, n_r}) ? W'(s - {1'b0, n_r}) : s[W-1:0];
    prod = s1;
  end

  // residue digits, MSB first
  always_comb begin
    v3 = {r3_r, sr_r[W-1]};
    v5 = {r5_r, sr_r[W-1]};
    v7 = {r7_r, sr_r[W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      neg_r  <= 1'b0;
      d_r    <= '0;
      twos_r <= '0;
      acc_r  <= W'(1);
      base_r <= '0;
      exp_r  <= '0;
    end else begin
      if (cmd.load) begin
        n_r   <= value;
        neg_r <= treat_signed & value[W-1];
      end
      if (cmd.prep_start) begin
        sr_r   <= n_r;
        d_r    <= nm1;
        twos_r <= '0;
        r3_r   <= '0;
        r5_r   <= '0;
        r7_r   <= '0;
      end else if (cmd.prep_step) begin
        sr_r <= {sr_r[W-2:0], 1'b0};
        r3_r <= (v3 >= 3'd3) ? 2'(v3 - 3'd3) : v3[1:0];
        r5_r <= (v5 >= 4'd5) ? 3'(v5 - 4'd5) : v5[2:0];
        r7_r <= (v7 >= 4'd7) ? 3'(v7 - 4'd7) : v7[2:0];
        if (!d_r[0]) begin
          d_r    <= {1'b0, d_r[W-1:1]};
          twos_r <= twos_r + TWOS_W'(1);
        end
      end
      if (cmd.round_init) begin
        acc_r  <= W'(1);
        base_r <= W'(witness(set_c, widx_r));
        exp_r  <= d_r;
      end
      if (cmd.mul_start) begin
        op_r   <= cmd.mul_op;
        mb_r   <= mul_b;
        macc_r <= '0;
        mcnt_r <= '0;
      end else if (cmd.mul_step) begin
        mb_r   <= {mb_r[W-2:0], 1'b0};
        macc_r <= prod;
        mcnt_r <= mcnt_r + MCNT_W'(1);
        if (sts.mul_last) begin
          unique case (op_r)
            MUL_SQB: begin
              base_r <= prod;
              exp_r  <= {1'b0, exp_r[W-1:1]};
            end
            default: acc_r <= prod;
          endcase
        end
      end
      if (cmd.left_load)     left_r <= twos_r;
      else if (cmd.left_dec) left_r <= left_r - TWOS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      widx_r <= '0;
    end else begin
      if (cmd.prep_start)     cnt_r <= '0;
      else if (cmd.prep_step) cnt_r <= cnt_r + MCNT_W'(1);
      if (cmd.widx_clr)       widx_r <= '0;
      else if (cmd.widx_inc)  widx_r <= widx_r + WIDX_W'(1);
    end
  end

  always_comb begin
    sts.trivial       = neg_r || (n_r <= W'(2)) || !n_r[0] || (n_r < W'(9));
    sts.trivial_prime = !neg_r && ((n_r == W'(2)) || (n_r[0] && n_r > W'(1) && n_r < W'(9)));
    sts.prep_last     = (cnt_r == MCNT_W'(W - 1));
    sts.small_div     = (r3_r == 2'd0) || (r5_r == 3'd0) || (r7_r == 3'd0);
    sts.exp_zero      = (exp_r == '0);
    sts.exp_bit0      = exp_r[0];
    sts.mul_last      = (mcnt_r == MCNT_W'(W - 1));
    sts.x_one_or_nm1  = (acc_r == W'(1)) || (acc_r == nm1);
    sts.x_nm1         = (acc_r == nm1);
    sts.left_gt1      = (left_r > TWOS_W'(1));
    sts.last_witness  = (widx_r == set_count(set_c) - WIDX_W'(1));
  end

endmodule
`default_nettype wire

// File: src/mrpt_ctrl.sv
// Controller of the Miller-Rabin prime test: sequences the datapath and holds
// the output register. Depends on mrpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrpt_ctrl import mrpt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_fire,
  input  wire logic         out_tready,
  input  wire mrpt_status_t sts,
  output mrpt_cmd_t         cmd,
  output logic              idle,
  output logic              out_valid,
  output logic              out_prime
);
  mrpt_state_t state_r, state_nxt;
  logic        verdict_r, verdict_nxt, ovalid_r, ovalid_nxt, oprime_r, oprime_nxt;

  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    unique case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_CLASS;
      ST_CLASS:   begin
        if (sts.trivial) begin
          verdict_nxt = sts.trivial_prime;
          state_nxt   = ST_RESULT;
        end else state_nxt = ST_PREP;
      end
      ST_PREP:    if (sts.prep_last) state_nxt = ST_SMALL;
      ST_SMALL:   begin
        if (sts.small_div) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_RESULT;
        end else state_nxt = ST_RINIT;
      end
      ST_RINIT:   state_nxt = ST_EXPCHK;
      ST_EXPCHK:  begin
        priority if (sts.exp_zero) state_nxt = ST_XCHK;
        else if (sts.exp_bit0)     state_nxt = ST_MULA;
        else                       state_nxt = ST_MULB;
      end
      ST_MULA:    if (sts.mul_last) state_nxt = ST_SQB_GO;
      ST_SQB_GO:  state_nxt = ST_MULB;
      ST_MULB:    if (sts.mul_last) state_nxt = ST_EXPCHK;
      ST_XCHK:    state_nxt = sts.x_one_or_nm1 ? ST_NEXTW : ST_LOOPCHK;
      ST_LOOPCHK: begin
        if (sts.left_gt1) state_nxt = ST_MULX;
        else begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_RESULT;
        end
      end
      ST_MULX:    if (sts.mul_last) state_nxt = ST_SQCHK;
      ST_SQCHK:   state_nxt = sts.x_nm1 ? ST_NEXTW : ST_LOOPCHK;
      ST_NEXTW:   begin
        if (sts.last_witness) begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_RESULT;
        end else state_nxt = ST_RINIT;
      end
      ST_RESULT:  if (!ovalid_r || out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_ACC;
    ovalid_nxt = ovalid_r && !out_tready;
    oprime_nxt = oprime_r;
    unique case (state_r)
      ST_IDLE:    cmd.load = in_fire;
      ST_CLASS:   cmd.prep_start = 1'b1;
      ST_PREP:    cmd.prep_step = 1'b1;
      ST_SMALL:   cmd.widx_clr = 1'b1;
      ST_RINIT:   cmd.round_init = 1'b1;
      ST_EXPCHK:  begin
        cmd.mul_start = !sts.exp_zero;
        cmd.mul_op    = sts.exp_bit0 ? MUL_ACC : MUL_SQB;
      end
      ST_MULA, ST_MULB, ST_MULX: cmd.mul_step = 1'b1;
      ST_SQB_GO:  begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = MUL_SQB;
      end
      ST_XCHK:    cmd.left_load = 1'b1;
      ST_LOOPCHK: begin
        cmd.mul_start = sts.left_gt1;
        cmd.mul_op    = MUL_SQX;
        cmd.left_dec  = sts.left_gt1;
      end
      ST_SQCHK:   ;
      ST_NEXTW:   cmd.widx_inc = !sts.last_witness;
      ST_RESULT:  begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oprime_nxt = verdict_r;
        end
      end
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ovalid_r  <= 1'b0;
      verdict_r <= 1'b0;
      oprime_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= ovalid_nxt;
      verdict_r <= verdict_nxt;
      oprime_r  <= oprime_nxt;
    end
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_prime = oprime_r;

endmodule
`default_nettype wire

// File: src/miller_rabin_prime_test_64.sv
// Top level of the 64-bit deterministic Miller-Rabin prime test.
// Instantiates mrpt_ctrl and mrpt_dp; depends on mrpt_pkg.
//
// Usage:
//   Input stream: in_tdata carries the 64-bit candidate, in_tuser the
//   signed flag (top bit set then means negative, answered not prime).
//   One transfer in gives exactly one transfer out: out_tdata[0] = is_prime.
//   in_tready is high only while the block is idle; one candidate is
//   processed at a time.
//   Small cases (<= 8, even, negative) are answered straight after the
//   classify state; others first run the residue/twos scan, then each
//   Miller-Rabin round runs modular multiplications on the bit-serial
//   multiplier (one multiplier bit per cycle): one or two per exponent bit
//   plus one per extra squaring. A 64-bit prime takes up to twelve rounds;
//   the multiplications dominate the run time.
//   The result sits in an output register; a new candidate is accepted
//   while it waits. If the receiver stalls, the next result holds in the
//   controller until the output register frees.
//   Reset (rst_n low, synchronous) returns the controller to idle and drops
//   any pending result.
`timescale 1ns / 1ps
`default_nettype none
module miller_rabin_prime_test_64 import mrpt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [VALUE_WIDTH-1:0] in_tdata,   // [63:0] value
  input  wire logic                   in_tuser,   // [0] treat_signed
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [7:0]                  out_tdata   // [0] is_prime, [7:1] zero
);
  mrpt_cmd_t    cmd;
  mrpt_status_t sts;
  logic         idle, prime;

  // a transfer in happens only from idle
  assign in_tready = idle;

  mrpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid && idle),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle),
    .out_valid (out_tvalid),
    .out_prime (prime)
  );

  mrpt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .value       (in_tdata),
    .treat_signed(in_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign out_tdata = {7'd0, prime};

endmodule
`default_nettype wire
